>>> sv/hte_pkg.sv
// ============================================================================
// hte_pkg: shared types and constants of the hover thrust estimator
// Item structs, sequencer states, register indexes and fixed-point constants.
// ============================================================================
package hte_pkg;

  // Fixed-point constants
  localparam logic [19:0] GRAV_Q16 = 20'd642253;          // 9.8 in Q4.16
  localparam logic [30:0] HM_MAX   = 31'h7FFF_FFFF;       // slope ceiling
  localparam logic [46:0] KM_MAX   = 47'h7FFF_FFFF_FFFF;  // gain ceiling
  localparam logic signed [54:0] EST_MAX = 55'sd8388607;
  localparam logic signed [54:0] EST_MIN = -55'sd8388608;

  // Register defaults
  localparam logic [31:0] PROCESS_NOISE_DEF = 32'd268435;
  localparam logic [31:0] MEASURE_NOISE_DEF = 32'd268435456;
  localparam logic [31:0] INIT_VAR_DEF      = 32'd268435456;
  localparam logic [15:0] INIT_THRUST_DEF   = 16'd19661;
  localparam logic [15:0] CONV_BAND_DEF     = 16'd328;

  localparam int WINDOW_DEPTH_DEF = 10;

  // Divider geometry
  localparam int DIV_REM_W  = 64;
  localparam int DIV_LOW_W  = 48;
  localparam int DIV_STEP_W = 6;

  typedef enum logic [2:0] {
    CFG_PROCESS_NOISE = 3'd0,
    CFG_MEASURE_NOISE = 3'd1,
    CFG_INIT_VAR      = 3'd2,
    CFG_INIT_THRUST   = 3'd3,
    CFG_CONV_BAND     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               ready_req;
    logic [15:0]        cmd_thrust;
    logic signed [23:0] vertical_accel;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        held_thrust;
    logic signed [23:0] new_estimate;
    logic [31:0]        estimate_var;
    logic               accepted;
    logic               failed;
    logic               skipped;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_LOW_W-1:0]  low;
    logic [DIV_REM_W-1:0]  divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_LOW_W-1:0]  quot;
  } div_stat_t;

  typedef struct packed {
    logic               full;
    logic               done;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
  } win_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GC,
    ST_HH,
    ST_HM_GO,
    ST_HM_WAIT,
    ST_HP0,
    ST_HP1,
    ST_HP2,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_KM_GO,
    ST_KM_WAIT,
    ST_GR_GO,
    ST_GR_WAIT,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_EST,
    ST_PR0,
    ST_PR1,
    ST_PR2,
    ST_PN_GO,
    ST_PN_WAIT,
    ST_WIN,
    ST_SCAN_GO,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

>>> sv/hte_mul.sv
// ============================================================================
// hte_mul: shared 48 x 16 multiplier
// Unsigned product, registered; wider products are built from 16-bit slices.
// ============================================================================
module hte_mul (
  input  logic        clk,
  input  logic [47:0] a,
  input  logic [15:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> sv/hte_div.sv
// ============================================================================
// hte_div: shared restoring divider
// One quotient bit per cycle from a preloaded partial remainder.
// ============================================================================
module hte_div (
  input  logic                clk,
  input  logic                rst,
  input  hte_pkg::div_req_t   req,
  output hte_pkg::div_stat_t  stat
);

  logic [hte_pkg::DIV_REM_W-1:0]  rem;
  logic [hte_pkg::DIV_REM_W-1:0]  dvs;
  logic [hte_pkg::DIV_LOW_W-1:0]  low;
  logic [hte_pkg::DIV_LOW_W-1:0]  quot;
  logic [hte_pkg::DIV_STEP_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [hte_pkg::DIV_REM_W:0]    cand;
  logic                           fits;

  assign cand = {rem, low[hte_pkg::DIV_LOW_W-1]};
  assign fits = cand >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == hte_pkg::DIV_STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      dvs  <= req.divisor;
      low  <= req.low;
      cnt  <= req.steps;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? hte_pkg::DIV_REM_W'(cand - {1'b0, dvs})
                   : cand[hte_pkg::DIV_REM_W-1:0];
      low  <= {low[hte_pkg::DIV_LOW_W-2:0], 1'b0};
      quot <= {quot[hte_pkg::DIV_LOW_W-2:0], fits};
      cnt  <= cnt - hte_pkg::DIV_STEP_W'(1);
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

>>> sv/hte_win.sv
// ============================================================================
// hte_win: estimate window with min/max scan
// Circular store of recent estimates and a one-entry-a-cycle spread scan.
// ============================================================================
module hte_win #(
  parameter int WINDOW_DEPTH = hte_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic signed [23:0] wr_data,
  input  logic               scan_start,
  output hte_pkg::win_stat_t stat
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  logic signed [23:0] win [WINDOW_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [FW-1:0]      fill;
  logic [PW-1:0]      sidx;
  logic               scanning;
  logic               done;
  logic signed [23:0] lo;
  logic signed [23:0] hi;
  logic signed [23:0] cur;

  assign cur = win[sidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      fill     <= '0;
      scanning <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
        if (fill != FW'(WINDOW_DEPTH)) begin
          fill <= fill + FW'(1);
        end
      end
      if (scan_start) begin
        scanning <= 1'b1;
      end else if (scanning && sidx == PW'(WINDOW_DEPTH - 1)) begin
        scanning <= 1'b0;
        done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win[wr_ptr] <= wr_data;
    end
    if (scan_start) begin
      sidx <= PW'(1);
      lo   <= win[0];
      hi   <= win[0];
    end else if (scanning) begin
      sidx <= sidx + PW'(1);
      if (cur < lo) begin
        lo <= cur;
      end
      if (cur > hi) begin
        hi <= cur;
      end
    end
  end

  assign stat.full = (fill == FW'(WINDOW_DEPTH));
  assign stat.done = done;
  assign stat.lo   = lo;
  assign stat.hi   = hi;

endmodule

>>> sv/hover_thrust_estimator.sv
// ============================================================================
// hover_thrust_estimator: one-state Kalman estimator of hover thrust
// Sequencer around a shared multiplier, a shared divider and an estimate window.
// ============================================================================
// Each item carries the commanded thrust and the vertical acceleration. A
// skipped item (ready_req low, or the first ready item after reset) goes
// straight from idle to the final state; its result is offered, and the
// block is ready again, once the final state finds the output register free.
// A full update is set by four restoring divisions on the one shared divider
// (31, 47, 36 and 32 quotient bits), with the window spread scan added once
// the window is full. Saturated slope or gain, and a zero innovation
// variance, bypass the matching division and shorten the update. A result
// that cannot leave holds the sequencer in its last state until the output
// register is free. The block takes one item at a time: in_ready is high
// only while the sequencer is idle, but a finished result may wait in the
// output register while the next item is accepted. Configuration registers
// are written through cfg_we, cfg_addr and cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not
// enforce. Writing the initial variance or the initial hover thrust also
// reloads the live value at once.
module hover_thrust_estimator #(
  parameter int WINDOW_DEPTH = hte_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hte_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  // Configuration and persistent state
  logic [31:0] process_noise_var;
  logic [31:0] measure_noise_var;
  logic [31:0] initial_state_var;
  logic [15:0] initial_hover_thrust;
  logic [15:0] convergence_band;
  logic [15:0] accepted_thrust;
  logic [31:0] est_variance;
  logic        first_pending;

  hte_pkg::state_t state, state_next;

  // Per-item working registers
  logic [15:0]        c_in;
  logic signed [23:0] a_in;
  logic [15:0]        h;
  logic [31:0]        p;
  logic [35:0]        gc;
  logic [30:0]        hm;
  logic [62:0]        n;
  logic [62:0]        s;
  logic [46:0]        km;
  logic [36:0]        mag;
  logic               neg;
  logic [84:0]        acc;
  logic signed [23:0] est;
  logic [31:0]        pn;
  logic               skip_flag;
  logic               acc_flag;
  logic               fail_flag;

  // Shared units
  logic [47:0]         mul_a;
  logic [15:0]         mul_b;
  logic [63:0]         prod;
  hte_pkg::div_req_t   div_req;
  hte_pkg::div_stat_t  div_stat;
  logic                win_wr;
  logic                scan_start;
  hte_pkg::win_stat_t  win_stat;

  // Derived values
  logic               in_acc;
  logic               out_free;
  logic [32:0]        p_sum;
  logic [46:0]        x;
  logic signed [37:0] innov;
  logic signed [54:0] est_wide;
  logic [52:0]        delta;
  logic [24:0]        spread;
  logic               hm_sat;
  logic               km_sat;

  assign in_ready = (state == hte_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign p_sum    = {1'b0, est_variance} + {1'b0, process_noise_var};
  assign x        = n[62:16];
  assign innov    = {{14{a_in[23]}}, a_in} - {2'b00, div_stat.quot[35:0]};
  assign delta    = acc[84:32];
  assign est_wide = neg ? ($signed({39'd0, accepted_thrust}) + $signed({2'b00, delta}))
                        : ($signed({39'd0, accepted_thrust}) - $signed({2'b00, delta}));
  assign spread   = {win_stat.hi[23], win_stat.hi} - {win_stat.lo[23], win_stat.lo};
  assign hm_sat   = {11'd0, gc[35:15]} >= prod[31:0];
  assign km_sat   = {31'd0, n[62:31]} >= s;

  hte_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  hte_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  hte_win #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (win_wr),
    .wr_data    (est),
    .scan_start (scan_start),
    .stat       (win_stat)
  );

  // Sequencer: next state and unit operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    win_wr     = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      hte_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_data.ready_req || first_pending) begin
            state_next = hte_pkg::ST_FIN;
          end else begin
            state_next = hte_pkg::ST_GC;
          end
        end
      end
      hte_pkg::ST_GC: begin
        mul_a      = {28'd0, hte_pkg::GRAV_Q16};
        mul_b      = c_in;
        state_next = hte_pkg::ST_HH;
      end
      hte_pkg::ST_HH: begin
        mul_a      = {32'd0, h};
        mul_b      = h;
        state_next = hte_pkg::ST_HM_GO;
      end
      hte_pkg::ST_HM_GO: begin
        // Slope H = 9.8*c/h^2 in Q15.16: quotient of gc<<16 by h*h
        if (hm_sat) begin
          state_next = hte_pkg::ST_HP0;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = {43'd0, gc[35:15]};
          div_req.low      = {gc[14:0], 33'd0};
          div_req.divisor  = {32'd0, prod[31:0]};
          div_req.steps    = 6'd31;
          state_next       = hte_pkg::ST_HM_WAIT;
        end
      end
      hte_pkg::ST_HM_WAIT: begin
        if (div_stat.done) begin
          state_next = hte_pkg::ST_HP0;
        end
      end
      hte_pkg::ST_HP0: begin
        mul_a      = {17'd0, hm};
        mul_b      = p[15:0];
        state_next = hte_pkg::ST_HP1;
      end
      hte_pkg::ST_HP1: begin
        mul_a      = {17'd0, hm};
        mul_b      = p[31:16];
        state_next = hte_pkg::ST_HP2;
      end
      hte_pkg::ST_HP2: begin
        state_next = hte_pkg::ST_T0;
      end
      hte_pkg::ST_T0: begin
        mul_a      = {1'b0, x};
        mul_b      = {1'b0, hm[30:16]};
        state_next = hte_pkg::ST_T1;
      end
      hte_pkg::ST_T1: begin
        mul_a      = {1'b0, x};
        mul_b      = hm[15:0];
        state_next = hte_pkg::ST_T2;
      end
      hte_pkg::ST_T2: begin
        state_next = hte_pkg::ST_KM_GO;
      end
      hte_pkg::ST_KM_GO: begin
        // Gain K = P*H/S in Q15.32, skipped when S is zero or K saturates
        if (s == '0 || km_sat) begin
          state_next = hte_pkg::ST_GR_GO;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = {32'd0, n[62:31]};
          div_req.low      = {n[30:0], 17'd0};
          div_req.divisor  = {1'b0, s};
          div_req.steps    = 6'd47;
          state_next       = hte_pkg::ST_KM_WAIT;
        end
      end
      hte_pkg::ST_KM_WAIT: begin
        if (div_stat.done) begin
          state_next = hte_pkg::ST_GR_GO;
        end
      end
      hte_pkg::ST_GR_GO: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.low      = {gc, 12'd0};
        div_req.divisor  = {48'd0, h};
        div_req.steps    = 6'd36;
        state_next       = hte_pkg::ST_GR_WAIT;
      end
      hte_pkg::ST_GR_WAIT: begin
        if (div_stat.done) begin
          state_next = hte_pkg::ST_D0;
        end
      end
      hte_pkg::ST_D0: begin
        mul_a      = {1'b0, km};
        mul_b      = mag[15:0];
        state_next = hte_pkg::ST_D1;
      end
      hte_pkg::ST_D1: begin
        mul_a      = {1'b0, km};
        mul_b      = mag[31:16];
        state_next = hte_pkg::ST_D2;
      end
      hte_pkg::ST_D2: begin
        mul_a      = {1'b0, km};
        mul_b      = {11'd0, mag[36:32]};
        state_next = hte_pkg::ST_D3;
      end
      hte_pkg::ST_D3: begin
        state_next = hte_pkg::ST_EST;
      end
      hte_pkg::ST_EST: begin
        state_next = hte_pkg::ST_PR0;
      end
      hte_pkg::ST_PR0: begin
        if (s == '0) begin
          state_next = hte_pkg::ST_WIN;
        end else begin
          mul_a      = {16'd0, p};
          mul_b      = measure_noise_var[15:0];
          state_next = hte_pkg::ST_PR1;
        end
      end
      hte_pkg::ST_PR1: begin
        mul_a      = {16'd0, p};
        mul_b      = measure_noise_var[31:16];
        state_next = hte_pkg::ST_PR2;
      end
      hte_pkg::ST_PR2: begin
        state_next = hte_pkg::ST_PN_GO;
      end
      hte_pkg::ST_PN_GO: begin
        // Updated variance P*R/S, which never exceeds P
        div_req.start    = 1'b1;
        div_req.rem_init = {32'd0, acc[63:32]};
        div_req.low      = {acc[31:0], 16'd0};
        div_req.divisor  = {1'b0, s};
        div_req.steps    = 6'd32;
        state_next       = hte_pkg::ST_PN_WAIT;
      end
      hte_pkg::ST_PN_WAIT: begin
        if (div_stat.done) begin
          state_next = hte_pkg::ST_WIN;
        end
      end
      hte_pkg::ST_WIN: begin
        win_wr = 1'b1;
        if (win_stat.full) begin
          state_next = hte_pkg::ST_SCAN_GO;
        end else begin
          state_next = hte_pkg::ST_FIN;
        end
      end
      hte_pkg::ST_SCAN_GO: begin
        scan_start = 1'b1;
        state_next = hte_pkg::ST_SCAN;
      end
      hte_pkg::ST_SCAN: begin
        if (win_stat.done) begin
          state_next = hte_pkg::ST_FIN;
        end
      end
      hte_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = hte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, configuration and the committed estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise_var    <= hte_pkg::PROCESS_NOISE_DEF;
      measure_noise_var    <= hte_pkg::MEASURE_NOISE_DEF;
      initial_state_var    <= hte_pkg::INIT_VAR_DEF;
      initial_hover_thrust <= hte_pkg::INIT_THRUST_DEF;
      convergence_band     <= hte_pkg::CONV_BAND_DEF;
      accepted_thrust      <= hte_pkg::INIT_THRUST_DEF;
      est_variance         <= hte_pkg::INIT_VAR_DEF;
      first_pending        <= 1'b1;
      out_valid            <= 1'b0;
    end else begin
      if (in_acc && in_data.ready_req) begin
        first_pending <= 1'b0;
      end
      // A new result takes the output register as the old one leaves
      if (state == hte_pkg::ST_FIN && out_free) begin
        out_valid <= 1'b1;
        if (!skip_flag) begin
          est_variance <= pn;
        end
        if (acc_flag) begin
          accepted_thrust <= est[15:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          hte_pkg::CFG_PROCESS_NOISE: begin
            process_noise_var <= cfg_wdata;
          end
          hte_pkg::CFG_MEASURE_NOISE: begin
            measure_noise_var <= cfg_wdata;
          end
          hte_pkg::CFG_INIT_VAR: begin
            initial_state_var <= cfg_wdata;
            est_variance      <= cfg_wdata;
          end
          hte_pkg::CFG_INIT_THRUST: begin
            initial_hover_thrust <= cfg_wdata[15:0];
            accepted_thrust      <= cfg_wdata[15:0];
          end
          hte_pkg::CFG_CONV_BAND: begin
            convergence_band <= cfg_wdata[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    unique case (state)
      hte_pkg::ST_IDLE: begin
        if (in_acc) begin
          c_in      <= in_data.cmd_thrust;
          a_in      <= in_data.vertical_accel;
          // A zero hover thrust divides as one LSB
          h         <= (accepted_thrust == '0) ? 16'd1 : accepted_thrust;
          p         <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
          skip_flag <= !in_data.ready_req || first_pending;
          acc_flag  <= 1'b0;
          fail_flag <= 1'b0;
          est       <= '0;
          hm        <= hte_pkg::HM_MAX;
          km        <= '0;
        end
      end
      hte_pkg::ST_HH: begin
        gc <= prod[35:0];
      end
      hte_pkg::ST_HM_WAIT: begin
        if (div_stat.done) begin
          hm <= div_stat.quot[30:0];
        end
      end
      hte_pkg::ST_HP1: begin
        acc <= {21'd0, prod};
      end
      hte_pkg::ST_HP2: begin
        n <= acc[62:0] + {prod[46:0], 16'd0};
      end
      hte_pkg::ST_T1: begin
        acc <= {21'd0, prod};
      end
      hte_pkg::ST_T2: begin
        s <= acc[62:0] + {15'd0, prod[63:16]} + {31'd0, measure_noise_var};
      end
      hte_pkg::ST_KM_GO: begin
        if (s != '0 && km_sat) begin
          km <= hte_pkg::KM_MAX;
        end
      end
      hte_pkg::ST_KM_WAIT: begin
        if (div_stat.done) begin
          km <= div_stat.quot[46:0];
        end
      end
      hte_pkg::ST_GR_WAIT: begin
        // Innovation a - 9.8*c/h; its magnitude scales the correction
        if (div_stat.done) begin
          neg <= innov[37];
          mag <= innov[37] ? 37'(-innov) : innov[36:0];
        end
      end
      hte_pkg::ST_D1: begin
        acc <= {21'd0, prod};
      end
      hte_pkg::ST_D2: begin
        acc <= acc + {5'd0, prod, 16'd0};
      end
      hte_pkg::ST_D3: begin
        acc <= acc + {prod[52:0], 32'd0};
      end
      hte_pkg::ST_EST: begin
        if (est_wide > hte_pkg::EST_MAX) begin
          est <= 24'sh7F_FFFF;
        end else if (est_wide < hte_pkg::EST_MIN) begin
          est <= -24'sh80_0000;
        end else begin
          est <= est_wide[23:0];
        end
      end
      hte_pkg::ST_PR0: begin
        if (s == '0) begin
          pn <= p;
        end
      end
      hte_pkg::ST_PR1: begin
        acc <= {21'd0, prod};
      end
      hte_pkg::ST_PR2: begin
        acc <= acc + {5'd0, prod, 16'd0};
      end
      hte_pkg::ST_PN_WAIT: begin
        if (div_stat.done) begin
          pn <= div_stat.quot[31:0];
        end
      end
      hte_pkg::ST_SCAN: begin
        // Converged window: accept an estimate strictly inside (0,1)
        if (win_stat.done && spread < {9'd0, convergence_band}) begin
          if (!est[23] && est[22:16] == '0 && est != '0) begin
            acc_flag <= 1'b1;
          end else begin
            fail_flag <= 1'b1;
          end
        end
      end
      hte_pkg::ST_FIN: begin
        if (out_free) begin
          out_data.held_thrust  <= acc_flag ? est[15:0] : accepted_thrust;
          out_data.new_estimate <= est;
          out_data.estimate_var <= skip_flag ? est_variance : pn;
          out_data.accepted     <= acc_flag;
          out_data.failed       <= fail_flag;
          out_data.skipped      <= skip_flag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
